@@ design/irm_pkg.sv @@
package irm_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } irm_state_e;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic KIND_ASSIGN = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

endpackage

@@ design/irm_table.sv @@
// Breakpoint store: one write port and one read port with registered read data.
module irm_table #(
  parameter int AW = 7,
  parameter int DW = 64
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/interval_range_map.sv @@
// A transaction walks the live table in ST_SCAN, then passes through ST_FINISH
// before it raises done_o; an assign with an empty range is answered from idle.
// Throughput: one transaction at a time, set by the single read port of the table,
// walked one breakpoint per cycle except while an assign emits its start or stop.
// Reset: asynchronous, active low; the table is empty and base_value is zero.
// Results are shown for one cycle on done_o and cannot be stalled.
module interval_range_map
  import irm_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  kind_i,
  input  logic [KEY_BITS-1:0]   key_start_i,
  input  logic [KEY_BITS-1:0]   key_stop_i,
  input  logic [VALUE_BITS-1:0] new_value_i,
  input  logic                  cfg_we_i,
  input  logic [VALUE_BITS-1:0] cfg_wdata_i,
  output logic                  done_o,
  output logic [VALUE_BITS-1:0] read_value_o,
  output logic [1:0]            status_o
);

  // Index width of one bank, width of the live count, and width of the rebuild
  // count, which may run up to two beyond the capacity before it is rejected.
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int NW = $clog2(CAPACITY + 3);
  localparam int DW = KEY_BITS + VALUE_BITS;

  // The memory holds two banks. The live table sits in the bank selected by
  // bank_q; an assign rebuilds the table into the other bank while streaming
  // the live one, and the banks swap only if the result fits. A failed assign
  // therefore leaves the live table untouched at no extra cost.
  irm_state_e            state_q, state_d;
  logic                  bank_q, bank_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [NW-1:0]         new_cnt_q, new_cnt_d;
  logic [VALUE_BITS-1:0] last_q, last_d;
  logic [VALUE_BITS-1:0] endv_q, endv_d;
  logic                  started_q, started_d;
  logic                  stopped_q, stopped_d;
  logic                  kind_q, kind_d;
  logic [KEY_BITS-1:0]   kstart_q, kstart_d;
  logic [KEY_BITS-1:0]   kstop_q, kstop_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [VALUE_BITS-1:0] base_q;
  logic                  done_q, done_d;
  logic [VALUE_BITS-1:0] rv_q, rv_d;
  logic [1:0]            st_q, st_d;

  logic                  push_en;
  logic [KEY_BITS-1:0]   push_k;
  logic [VALUE_BITS-1:0] push_v;
  logic                  re;
  logic [IW-1:0]         ridx;
  logic                  we;
  logic [DW-1:0]         rdata;
  logic [KEY_BITS-1:0]   rk;
  logic [VALUE_BITS-1:0] rv;

  assign rk = rdata[DW-1:VALUE_BITS];
  assign rv = rdata[VALUE_BITS-1:0];

  irm_table #(
    .AW(IW + 1),
    .DW(DW)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i({~bank_q, new_cnt_q[IW-1:0]}),
    .wdata_i({push_k, push_v}),
    .re_i   (re),
    .raddr_i({bank_q, ridx}),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d   = state_q;
    bank_d    = bank_q;
    count_d   = count_q;
    idx_d     = idx_q;
    last_d    = last_q;
    endv_d    = endv_q;
    started_d = started_q;
    stopped_d = stopped_q;
    kind_d    = kind_q;
    kstart_d  = kstart_q;
    kstop_d   = kstop_q;
    val_d     = val_q;
    done_d    = 1'b0;
    rv_d      = rv_q;
    st_d      = st_q;
    push_en   = 1'b0;
    push_k    = kstart_q;
    push_v    = val_q;
    re        = 1'b0;
    ridx      = idx_q[IW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          kind_d    = kind_i;
          kstart_d  = key_start_i;
          kstop_d   = key_stop_i;
          val_d     = new_value_i;
          last_d    = base_q;
          endv_d    = base_q;
          started_d = 1'b0;
          stopped_d = 1'b0;
          if (kind_i == KIND_ASSIGN && !(key_start_i < key_stop_i)) begin
            done_d = 1'b1;
            rv_d   = '0;
            st_d   = STATUS_EMPTY;
          end else if (count_q == '0) begin
            state_d = ST_FINISH;
          end else begin
            re      = 1'b1;
            ridx    = '0;
            idx_d   = CW'(1);
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // rk/rv hold the last breakpoint read, which stays until it is consumed. An assign may
        // emit the start and stop breakpoints ahead of it before it is consumed.
        logic consume;
        consume = 1'b0;
        if (kind_q == KIND_ASSIGN) begin
          priority if (!started_q && rk >= kstart_q) begin
            push_en   = 1'b1;
            started_d = 1'b1;
          end else if (started_q && !stopped_q && rk > kstop_q) begin
            push_en   = 1'b1;
            push_k    = kstop_q;
            push_v    = endv_q;
            stopped_d = 1'b1;
          end else begin
            consume = 1'b1;
            if (rk <= kstop_q) begin
              endv_d = rv;
            end
            if (rk < kstart_q || rk > kstop_q) begin
              push_en = 1'b1;
              push_k  = rk;
              push_v  = rv;
            end
          end
        end else begin
          consume = 1'b1;
          if (rk <= kstart_q) begin
            endv_d = rv;
          end
        end
        if (consume) begin
          if (idx_q < count_q) begin
            re    = 1'b1;
            idx_d = idx_q + CW'(1);
          end else begin
            state_d = ST_FINISH;
          end
        end
      end

      ST_FINISH: begin
        if (kind_q == KIND_LOOKUP) begin
          done_d  = 1'b1;
          rv_d    = endv_q;
          st_d    = STATUS_DONE;
          state_d = ST_IDLE;
        end else if (!started_q) begin
          push_en   = 1'b1;
          started_d = 1'b1;
        end else if (!stopped_q) begin
          push_en   = 1'b1;
          push_k    = kstop_q;
          push_v    = endv_q;
          stopped_d = 1'b1;
        end else begin
          done_d  = 1'b1;
          rv_d    = '0;
          state_d = ST_IDLE;
          if (new_cnt_q > NW'(CAPACITY)) begin
            st_d = STATUS_FULL;
          end else begin
            st_d    = STATUS_DONE;
            bank_d  = ~bank_q;
            count_d = new_cnt_q[CW-1:0];
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A pushed breakpoint that repeats the value in force is dropped.
    new_cnt_d = (state_q == ST_IDLE) ? '0 : new_cnt_q;
    we        = 1'b0;
    if (push_en && push_v != last_q) begin
      we        = new_cnt_q < NW'(CAPACITY);
      new_cnt_d = new_cnt_q + NW'(1);
      last_d    = push_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bank_q  <= 1'b0;
      count_q <= '0;
      base_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      bank_q  <= bank_d;
      count_q <= count_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    new_cnt_q <= new_cnt_d;
    last_q    <= last_d;
    endv_q    <= endv_d;
    started_q <= started_d;
    stopped_q <= stopped_d;
    kind_q    <= kind_d;
    kstart_q  <= kstart_d;
    kstop_q   <= kstop_d;
    val_q     <= val_d;
    rv_q      <= rv_d;
    st_q      <= st_d;
  end

  assign busy         = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign read_value_o = rv_q;
  assign status_o     = st_q;

endmodule

@@ design/irm_checker.sv @@
// Port-level checks for the interval map.
module irm_checker
  import irm_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start,
  input logic                  busy,
  input logic                  done_o,
  input logic [VALUE_BITS-1:0] read_value_o,
  input logic [1:0]            status_o
);

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted transaction neither busy nor done");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  a_busy_ends_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("transaction ended without a result");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == STATUS_DONE || status_o == STATUS_EMPTY ||
                status_o == STATUS_FULL))
    else $error("undefined status");

  a_assign_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != STATUS_DONE) |-> (read_value_o == '0))
    else $error("non-zero value with a failure status");

endmodule

bind interval_range_map irm_checker #(.VALUE_BITS(VALUE_BITS)) u_irm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .done_o      (done_o),
  .read_value_o(read_value_o),
  .status_o    (status_o)
);

@@ sim/testbench.sv @@
// Self-checking bench for the interval range map.
// Every accepted transaction is also run through a behavioural copy of the
// breakpoint table kept here. Its result is queued, and a monitor compares each
// strobed result against the oldest queued expectation, field by field.
module testbench
  import irm_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY = 64;
  localparam int CYCLE_LIMIT = 3_000_000;

  // Expected result of one transaction.
  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  status;
  } map_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        kind_i = KIND_ASSIGN;
  logic [31:0] key_start_i = '0;
  logic [31:0] key_stop_i = '0;
  logic [31:0] new_value_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        done_o;
  logic [31:0] read_value_o;
  logic [1:0]  status_o;

  // Shadow copy of the table and the base value.
  logic [31:0] shadow_keys[CAPACITY];
  logic [31:0] shadow_vals[CAPACITY];
  int          shadow_count;
  logic [31:0] shadow_base;

  map_result_t pending_results[$];
  int          error_count;
  int          cycle_count;
  // When set the sender inserts random idle cycles between transactions.
  bit          sender_gaps;

  interval_range_map dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .kind_i       (kind_i),
    .key_start_i  (key_start_i),
    .key_stop_i   (key_stop_i),
    .new_value_i  (new_value_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .done_o       (done_o),
    .read_value_o (read_value_o),
    .status_o     (status_o)
  );

  always #4 clk_i = ~clk_i;

  // Watchdog: a hung block must not stall the run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Number of breakpoints whose key is below the bound, or at most the bound.
  function automatic int keys_below(logic [31:0] bound, bit or_equal);
    int n;
    n = 0;
    for (int i = 0; i < shadow_count; i++)
      if (shadow_keys[i] < bound || (or_equal && shadow_keys[i] == bound)) n++;
    return n;
  endfunction

  function automatic logic [31:0] value_in_force(int pos);
    if (pos == 0) return shadow_base;
    return shadow_vals[pos - 1];
  endfunction

  // Rebuilds the table for a range assignment. Breakpoints that repeat the
  // value in force before them are dropped, which also clears out entries made
  // redundant by a change of base value. An overflow leaves the table alone.
  function automatic logic [1:0] assign_range(logic [31:0] lo_key, logic [31:0] hi_key,
                                              logic [31:0] value);
    logic [31:0] nk[$];
    logic [31:0] nv[$];
    logic [31:0] cand_k[$];
    logic [31:0] cand_v[$];
    logic [31:0] tail_val;
    logic [31:0] last;
    int lo;
    int hi;
    if (!(lo_key < hi_key)) return STATUS_EMPTY;
    lo = keys_below(lo_key, 1'b0);
    hi = keys_below(hi_key, 1'b1);
    tail_val = value_in_force(hi);
    for (int i = 0; i < lo; i++) begin
      cand_k.push_back(shadow_keys[i]);
      cand_v.push_back(shadow_vals[i]);
    end
    cand_k.push_back(lo_key);
    cand_v.push_back(value);
    cand_k.push_back(hi_key);
    cand_v.push_back(tail_val);
    for (int i = hi; i < shadow_count; i++) begin
      cand_k.push_back(shadow_keys[i]);
      cand_v.push_back(shadow_vals[i]);
    end
    for (int i = 0; i < cand_k.size(); i++) begin
      last = (nv.size() == 0) ? shadow_base : nv[$];
      if (cand_v[i] != last) begin
        nk.push_back(cand_k[i]);
        nv.push_back(cand_v[i]);
      end
    end
    if (nk.size() > CAPACITY) return STATUS_FULL;
    for (int i = 0; i < nk.size(); i++) begin
      shadow_keys[i] = nk[i];
      shadow_vals[i] = nv[i];
    end
    shadow_count = nk.size();
    return STATUS_DONE;
  endfunction

  // Drives one transaction and waits for its acceptance, then predicts it.
  // start is left high on return; whatever runs next at the same falling edge
  // either drives the next transaction or lowers it.
  task automatic send_item(logic kind, logic [31:0] k1, logic [31:0] k2, logic [31:0] v);
    map_result_t exp_res;
    if (sender_gaps) begin
      while ($urandom_range(99) < 14) begin
        start <= 1'b0;
        @(negedge clk_i);
      end
    end
    start <= 1'b1;
    kind_i <= kind;
    key_start_i <= k1;
    key_stop_i <= k2;
    new_value_i <= v;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    exp_res = '0;
    if (kind == KIND_LOOKUP) exp_res.read_value = value_in_force(keys_below(k1, 1'b1));
    else exp_res.status = assign_range(k1, k2, v);
    pending_results.push_back(exp_res);
    @(negedge clk_i);
  endtask

  // Waits for all results and lets the block settle; write_base calls it before it writes the base value.
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (CAPACITY + 10) @(negedge clk_i);
  endtask

  task automatic write_base(logic [31:0] value);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_base = value;
  endtask

  // Result monitor: the block cannot be held off, so every strobe is a result.
  always @(posedge clk_i) begin
    map_result_t exp_res;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: read_value %h status %0d", read_value_o, status_o);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (read_value_o !== exp_res.read_value) begin
          $error("read_value: expected %h, got %h", exp_res.read_value, read_value_o);
          error_count++;
        end
        if (status_o !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, status_o);
          error_count++;
        end
      end
    end
  end

  // Draws a key, mostly from a narrow band so that ranges overlap often.
  function automatic logic [31:0] pick_key();
    case ($urandom_range(9))
      0: return $urandom();
      1: return 32'hFFFF_FFF0 + $urandom_range(15);
      default: return $urandom_range(200);
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    if ($urandom_range(3) == 0) return $urandom();
    return $urandom_range(5);
  endfunction

  // Extremes of keys and values, empty ranges and lookups on an empty table.
  task automatic test_directed();
    send_item(KIND_LOOKUP, 32'h0, 32'h0, 32'h0);
    send_item(KIND_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(KIND_ASSIGN, 32'd10, 32'd10, 32'd7);
    send_item(KIND_ASSIGN, 32'd20, 32'd10, 32'd7);
    send_item(KIND_ASSIGN, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(KIND_LOOKUP, 32'hFFFF_FFFE, 32'h0, 32'h0);
    send_item(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_item(KIND_ASSIGN, 32'd5, 32'd9, 32'hA5A5_5A5A);
    send_item(KIND_ASSIGN, 32'd9, 32'd12, 32'hA5A5_5A5A);
    send_item(KIND_LOOKUP, 32'd4, 32'h0, 32'h0);
    send_item(KIND_LOOKUP, 32'd5, 32'h0, 32'h0);
    send_item(KIND_LOOKUP, 32'd11, 32'h0, 32'h0);
    send_item(KIND_LOOKUP, 32'd12, 32'h0, 32'h0);
    send_item(KIND_ASSIGN, 32'h0, 32'hFFFF_FFFF, 32'h0);
    send_item(KIND_ASSIGN, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0);
    send_item(KIND_LOOKUP, 32'h8000_0000, 32'h0, 32'h0);
  endtask

  // Fills the table with alternating values past the point where it reports full.
  task automatic test_table_full();
    for (int i = 0; i < 70; i++)
      send_item(KIND_ASSIGN, 32'd1000 + 2 * i, 32'd1001 + 2 * i, (i % 2) ? 32'd3 : 32'd4);
    send_item(KIND_LOOKUP, 32'd1001, 32'h0, 32'h0);
    send_item(KIND_ASSIGN, 32'd0, 32'hFFFF_FFFF, 32'd0);
  endtask

  // Changes the base value so that stored breakpoints become redundant.
  task automatic test_base_change();
    send_item(KIND_ASSIGN, 32'd50, 32'd60, 32'd9);
    write_base(32'd9);
    send_item(KIND_LOOKUP, 32'd55, 32'h0, 32'h0);
    send_item(KIND_ASSIGN, 32'd70, 32'd80, 32'd2);
    send_item(KIND_LOOKUP, 32'd10, 32'h0, 32'h0);
    write_base(32'hFFFF_FFFF);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(2) == 0)
        send_item(KIND_LOOKUP, pick_key(), $urandom(), $urandom());
      else
        send_item(KIND_ASSIGN, pick_key(), pick_key(), pick_value());
      // Occasionally let the block run dry before the next transaction.
      if ($urandom_range(99) == 0) drain();
    end
  endtask

  initial begin
    error_count = 0;
    cycle_count = 0;
    sender_gaps = 1'b1;
    shadow_count = 0;
    shadow_base = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_table_full();
    test_base_change();
    write_base(32'h0);
    test_random(500);
    write_base($urandom());
    sender_gaps = 1'b0;
    test_random(300);
    sender_gaps = 1'b1;
    write_base(32'd2);
    test_random(650);
    drain();

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
